// ----- rtl/core/ltk_pkg.sv -----
// Shared types, codes and keyword tables for the link event keyword tracker.
// No dependencies; every module of the block refers to this package.
package ltk_pkg;

  localparam int MAX_LINKS_DEF = 5;

  // Event codes carried in event_res.
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_CONNECT = 2'd1;
  localparam logic [1:0] EV_READY   = 2'd2;
  localparam logic [1:0] EV_CLOSED  = 2'd3;

  // Request types.
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_POLL = 1'b1;

  // Character constants.
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_DASH    = 8'h2D;
  localparam logic [7:0] CHAN_BASE    = 8'h30;
  localparam logic [7:0] SERVER_CHAN_RST = 8'h31;

  localparam logic [2:0] CONNECT_LEN = 3'd7;
  localparam logic [2:0] READY_LEN   = 3'd5;
  localparam logic [2:0] CLOSED_LEN  = 3'd6;

  // Configuration register indexes.
  localparam logic REG_SERVER_CHANNEL = 1'b0;

  // One finished scan, handed from the front end to the back end.
  typedef struct packed {
    logic [1:0] ev;
    logic [7:0] ch;
    logic       valid;
  } cmd_t;

  function automatic logic [7:0] connect_char(input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = 8'h43; // C
      3'd1:    c = 8'h4F; // O
      3'd2:    c = 8'h4E; // N
      3'd3:    c = 8'h4E; // N
      3'd4:    c = 8'h45; // E
      3'd5:    c = 8'h43; // C
      3'd6:    c = 8'h54; // T
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] ready_char(input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = 8'h72; // r
      3'd1:    c = 8'h65; // e
      3'd2:    c = 8'h61; // a
      3'd3:    c = 8'h64; // d
      3'd4:    c = 8'h79; // y
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] closed_char(input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = 8'h43; // C
      3'd1:    c = 8'h4C; // L
      3'd2:    c = 8'h4F; // O
      3'd3:    c = 8'h53; // S
      3'd4:    c = 8'h45; // E
      3'd5:    c = 8'h44; // D
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/core/ltk_in_if.sv -----
// Input channel of the link event keyword tracker: one response byte or poll.
// Stand-alone interface, no dependencies.
interface ltk_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] char_in;
  logic       last_available;

  modport source (output valid, req_type, char_in, last_available, input ready);
  modport sink   (input valid, req_type, char_in, last_available, output ready);
endinterface

// ----- rtl/core/ltk_out_if.sv -----
// Result channel of the link event keyword tracker: one item per finished scan.
// Stand-alone interface, no dependencies.
interface ltk_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic [7:0] channel;
  logic       channel_valid;
  logic       link_up;
  logic       server_link;

  modport source (output valid, event_res, channel, channel_valid, link_up, server_link,
                  input ready);
  modport sink   (input valid, event_res, channel, channel_valid, link_up, server_link,
                  output ready);
endinterface

// ----- rtl/core/ltk_front.sv -----
// Front end: keeps the scan state, matches the keywords and emits a command per
// finished scan. Depends on ltk_pkg and ltk_in_if.
module ltk_front #(
  parameter int MAX_LINKS = ltk_pkg::MAX_LINKS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  ltk_in_if.sink        in_ch,
  output logic          cmd_valid,
  output ltk_pkg::cmd_t cmd,
  input  logic          cmd_ready
);

  logic       first_seen;
  logic [7:0] captured_channel;
  logic [2:0] connect_progress;
  logic [2:0] ready_progress;
  logic [2:0] closed_progress;

  logic       accept;
  logic       finish;
  logic       advance_scan;
  logic [1:0] ev;
  logic [7:0] fin_ch;
  logic [7:0] cap;
  logic [7:0] ch_off;
  logic [2:0] cp_adv;
  logic [2:0] rp_adv;
  logic [2:0] clp_adv;

  assign in_ch.ready = cmd_ready;
  assign accept      = in_ch.valid && cmd_ready;

  always_comb begin
    cap = first_seen ? captured_channel : in_ch.char_in;

    cp_adv = (connect_progress < ltk_pkg::CONNECT_LEN &&
              ltk_pkg::connect_char(connect_progress) == in_ch.char_in)
             ? connect_progress + 3'd1 : 3'd0;
    rp_adv = (ready_progress < ltk_pkg::READY_LEN &&
              ltk_pkg::ready_char(ready_progress) == in_ch.char_in)
             ? ready_progress + 3'd1 : 3'd0;
    clp_adv = (closed_progress < ltk_pkg::CLOSED_LEN &&
               ltk_pkg::closed_char(closed_progress) == in_ch.char_in)
              ? closed_progress + 3'd1 : 3'd0;

    finish       = 1'b0;
    advance_scan = 1'b0;
    ev           = ltk_pkg::EV_NONE;
    fin_ch       = captured_channel;

    priority if (in_ch.req_type == ltk_pkg::REQ_POLL) begin
      finish = 1'b1;
    end else if (in_ch.char_in == ltk_pkg::CHAR_SPACE) begin
      finish = in_ch.last_available;
    end else if (in_ch.char_in == ltk_pkg::CHAR_PLUS) begin
      finish = 1'b1;
    end else begin
      fin_ch       = cap;
      advance_scan = 1'b1;
      priority if (cp_adv == ltk_pkg::CONNECT_LEN) begin
        finish = 1'b1;
        ev     = ltk_pkg::EV_CONNECT;
      end else if (rp_adv == ltk_pkg::READY_LEN) begin
        finish = 1'b1;
        ev     = ltk_pkg::EV_READY;
      end else if (clp_adv == ltk_pkg::CLOSED_LEN) begin
        finish = 1'b1;
        ev     = ltk_pkg::EV_CLOSED;
      end else begin
        finish = in_ch.last_available;
      end
    end

    // The channel indexes the link table when it lies in [base, base + MAX_LINKS).
    ch_off    = fin_ch - ltk_pkg::CHAN_BASE;
    cmd.ev    = ev;
    cmd.ch    = fin_ch;
    cmd.valid = (fin_ch >= ltk_pkg::CHAN_BASE) && (ch_off < 8'(MAX_LINKS));
  end

  assign cmd_valid = accept && finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_seen       <= 1'b0;
      captured_channel <= ltk_pkg::CHAR_DASH;
      connect_progress <= 3'd0;
      ready_progress   <= 3'd0;
      closed_progress  <= 3'd0;
    end else if (accept) begin
      if (finish) begin
        first_seen       <= 1'b0;
        captured_channel <= ltk_pkg::CHAR_DASH;
        connect_progress <= 3'd0;
        ready_progress   <= 3'd0;
        closed_progress  <= 3'd0;
      end else if (advance_scan) begin
        first_seen       <= 1'b1;
        captured_channel <= cap;
        connect_progress <= cp_adv;
        ready_progress   <= rp_adv;
        closed_progress  <= clp_adv;
      end
    end
  end

endmodule

// ----- rtl/core/ltk_queue.sv -----
// Two-entry queue of scan commands between front end and back end.
// Depends on ltk_pkg for the command type.
module ltk_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  input  ltk_pkg::cmd_t push_data,
  output logic          push_ready,
  output logic          pop_valid,
  output ltk_pkg::cmd_t pop_data,
  input  logic          pop_ready
);

  ltk_pkg::cmd_t entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/core/ltk_back.sv -----
// Back end: applies scan commands to the link table and server flag and holds
// the result register. Depends on ltk_pkg and ltk_out_if.
module ltk_back #(
  parameter int MAX_LINKS = ltk_pkg::MAX_LINKS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    server_channel,
  input  logic          cmd_valid,
  input  ltk_pkg::cmd_t cmd,
  output logic          cmd_ready,
  ltk_out_if.source     out_ch
);

  localparam int IDX_W = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;

  logic [MAX_LINKS-1:0] link_table;
  logic                 server_flag;
  logic                 out_valid;
  logic [1:0]           out_event;
  logic [7:0]           out_channel;
  logic                 out_chan_valid;
  logic                 out_link_up;
  logic                 out_server;

  logic                 take;
  logic [7:0]           ch_off;
  logic [IDX_W-1:0]     idx;
  logic                 is_server;
  logic                 server_next;
  logic                 link_up_next;

  assign cmd_ready = !out_valid || out_ch.ready;
  assign take      = cmd_valid && cmd_ready;
  assign ch_off    = cmd.ch - ltk_pkg::CHAN_BASE;
  assign idx       = ch_off[IDX_W-1:0];
  assign is_server = (cmd.ch == server_channel);

  always_comb begin
    server_next  = server_flag;
    link_up_next = link_table[0];
    unique case (cmd.ev)
      ltk_pkg::EV_CONNECT: begin
        link_up_next = 1'b1;
        if (is_server) begin
          server_next = 1'b1;
        end
      end
      ltk_pkg::EV_CLOSED: begin
        link_up_next = 1'b0;
        if (is_server) begin
          server_next = 1'b0;
        end
      end
      default: begin
        link_up_next = link_table[0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_table  <= '0;
      server_flag <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (take) begin
        out_valid   <= 1'b1;
        server_flag <= server_next;
        if (cmd.valid && cmd.ev == ltk_pkg::EV_CONNECT) begin
          link_table[idx] <= 1'b1;
        end else if (cmd.valid && cmd.ev == ltk_pkg::EV_CLOSED) begin
          link_table[idx] <= 1'b0;
        end
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_event      <= cmd.ev;
      out_channel    <= cmd.ch;
      out_chan_valid <= cmd.valid;
      out_link_up    <= link_up_next;
      out_server     <= server_next;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.event_res     = out_event;
  assign out_ch.channel       = out_channel;
  assign out_ch.channel_valid = out_chan_valid;
  assign out_ch.link_up       = out_link_up;
  assign out_ch.server_link   = out_server;

endmodule

// ----- rtl/core/link_event_keyword_tracker_top.sv -----
// Top level of the link event keyword tracker: configuration register, front
// end, command queue and back end. Depends on ltk_pkg, both interfaces and all
// ltk_* modules.
//
// Usage: in_ch carries one transfer per modem response byte (req_type 0) or per
// status poll (req_type 1). Bytes are scanned for the keywords CONNECT, ready
// and CLOSED; spaces are skipped and the first other byte of a scan is kept as
// the channel character. A scan ends on a keyword, on a plus byte, on a byte
// flagged last_available, or on a poll, and then exactly one transfer leaves on
// out_ch with the event, the channel, whether it names a link table entry, the
// returned link status and the server link flag.
// Throughput is one input transfer per cycle while in_ch.ready is high; the
// front end classifies each byte combinationally. The command of the transfer
// that ends a scan is registered in the queue and then in the back end's output
// register before it leaves on out_ch. When out_ch stalls, the two-entry queue
// absorbs results until it is full, and only then is in_ch.ready dropped.
// Reset clears the scan state, the link table and the server flag, and sets the
// server channel register to the character '1'. The user writes it over the APB
// port at byte address 0 only while the block is idle; nothing enforces it.
module link_event_keyword_tracker_top #(
  parameter int MAX_LINKS = ltk_pkg::MAX_LINKS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  ltk_in_if.sink      in_ch,
  ltk_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]    server_channel;
  logic          reg_write;
  logic          reg_hit;

  logic          front_valid;
  ltk_pkg::cmd_t front_cmd;
  logic          front_ready;
  logic          back_valid;
  ltk_pkg::cmd_t back_cmd;
  logic          back_ready;

  // The only register sits at byte address 0; address 4 decodes to nothing.
  assign pready    = 1'b1;
  assign reg_hit   = (paddr[2] == ltk_pkg::REG_SERVER_CHANNEL);
  assign reg_write = psel && penable && pwrite && reg_hit;
  assign prdata    = reg_hit ? {24'd0, server_channel} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      server_channel <= ltk_pkg::SERVER_CHAN_RST;
    end else if (reg_write) begin
      server_channel <= pwdata[7:0];
    end
  end

  ltk_front #(
    .MAX_LINKS(MAX_LINKS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .cmd_valid (front_valid),
    .cmd       (front_cmd),
    .cmd_ready (front_ready)
  );

  ltk_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_data  (front_cmd),
    .push_ready (front_ready),
    .pop_valid  (back_valid),
    .pop_data   (back_cmd),
    .pop_ready  (back_ready)
  );

  ltk_back #(
    .MAX_LINKS(MAX_LINKS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .server_channel (server_channel),
    .cmd_valid      (back_valid),
    .cmd            (back_cmd),
    .cmd_ready      (back_ready),
    .out_ch         (out_ch)
  );

endmodule
